>>> src/vtn_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the vertex transform and normalize block.
// Depends on nothing; every other file of the block imports it.
package vtn_pkg;

    localparam int NUM_REGS   = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int REG_SEL_W  = 3;
    localparam int CFG_W      = 64;
    localparam int ELEM_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int NRM_W      = 16;
    localparam int TR_SH      = 14;

    localparam int POS_PROD_W    = 64;
    localparam int POS_DIV_STEPS = 32;
    localparam int POS_STAGES    = 3 + POS_DIV_STEPS;

    localparam int NPROD_W       = 48;
    localparam int NV_W          = 50;
    localparam int NA_W          = 48;
    localparam int NN_W          = 30;
    localparam int SQ_W          = 60;
    localparam int SUM_W         = 64;
    localparam int SQRT_STEPS    = 32;
    localparam int LEN_W         = 32;
    localparam int NQ_SH         = 14;
    localparam int NRM_DIV_STEPS = 15;
    localparam int NRM_STAGES    = 8 + SQRT_STEPS + NRM_DIV_STEPS + 1;

    localparam int PIPE_LAT = NRM_STAGES;
    localparam int POS_PAD  = NRM_STAGES - POS_STAGES;

    localparam logic [CFG_W-1:0] REG_RESET [NUM_REGS] = '{
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000
    };

    typedef logic [3:0][3:0][ELEM_W-1:0] mat_t;
    typedef logic [2:0][NA_W-1:0] trio_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] pos_x;
        logic signed [ELEM_W-1:0] pos_y;
        logic signed [ELEM_W-1:0] pos_z;
        logic signed [NRM_W-1:0]  norm_x;
        logic signed [NRM_W-1:0]  norm_y;
        logic signed [NRM_W-1:0]  norm_z;
        logic                     last_vertex;
    } vtn_in_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] out_x;
        logic signed [ELEM_W-1:0] out_y;
        logic signed [ELEM_W-1:0] out_z;
        logic signed [NRM_W-1:0]  out_nx;
        logic signed [NRM_W-1:0]  out_ny;
        logic signed [NRM_W-1:0]  out_nz;
        logic                     w_zero_fault;
        logic                     normal_zero_fault;
        logic                     last_out;
    } vtn_out_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] out_x;
        logic signed [ELEM_W-1:0] out_y;
        logic signed [ELEM_W-1:0] out_z;
        logic                     w_zero_fault;
    } pos_res_t;

    typedef struct packed {
        logic signed [NRM_W-1:0] out_nx;
        logic signed [NRM_W-1:0] out_ny;
        logic signed [NRM_W-1:0] out_nz;
        logic                    normal_zero_fault;
    } nrm_res_t;

endpackage

>>> src/vtn_pos_path.sv
`timescale 1ns / 1ps
// Position pipeline: 4x4 transform, divide by w one quotient bit per stage, saturate.
// Depends on vtn_pkg; the result is delayed to line up with the normal pipeline.
module vtn_pos_path
(
    input  logic              clk,
    input  vtn_pkg::vtn_in_t  vertex,
    input  vtn_pkg::mat_t     mat,
    output vtn_pkg::pos_res_t res
);
    import vtn_pkg::*;

    logic signed [ELEM_W-1:0]     p_in [3];
    logic signed [POS_PROD_W-1:0] prod_reg [4][3];
    logic signed [ELEM_W-1:0]     tr_reg [4];
    logic signed [POS_PROD_W-1:0] acc_reg [4];
    logic [POS_PROD_W-1:0]        un_reg [3];
    logic [POS_PROD_W-1:0]        ud_reg;
    logic [2:0]                   neg_reg;
    logic                         wz_reg;

    logic [POS_PROD_W-1:0] drem_reg  [1:POS_DIV_STEPS][3];
    logic [ELEM_W-1:0]     dfeed_reg [1:POS_DIV_STEPS][3];
    logic [ELEM_W-1:0]     dq_reg    [1:POS_DIV_STEPS][3];
    logic [POS_PROD_W-1:0] dud_reg   [1:POS_DIV_STEPS];
    logic [2:0]            dovf_reg  [1:POS_DIV_STEPS];
    logic [2:0]            dneg_reg  [1:POS_DIV_STEPS];
    logic                  dwz_reg   [1:POS_DIV_STEPS];

    pos_res_t fin;
    pos_res_t pad_reg [POS_PAD];

    function automatic logic [ELEM_W-1:0] sat_q(logic [ELEM_W-1:0] q, logic ovf, logic neg);
        logic [ELEM_W:0]   mag;
        logic [ELEM_W:0]   lim;
        logic [ELEM_W-1:0] r;
        mag = ovf ? {1'b1, {ELEM_W{1'b0}}} : {1'b0, q};
        lim = (ELEM_W+1)'(1) << (ELEM_W - 1);
        if (neg)
        begin
            if (mag > lim)
                r = {1'b1, {(ELEM_W-1){1'b0}}};
            else
                r = ELEM_W'(-mag);
        end
        else
        begin
            if (mag >= lim)
                r = {1'b0, {(ELEM_W-1){1'b1}}};
            else
                r = mag[ELEM_W-1:0];
        end
        return r;
    endfunction

    assign p_in[0] = vertex.pos_x;
    assign p_in[1] = vertex.pos_y;
    assign p_in[2] = vertex.pos_z;

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                prod_reg[c][r] <= p_in[r] * $signed(mat[r][c]);
            end
            tr_reg[c] <= $signed(mat[3][c]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 4; c++)
        begin
            acc_reg[c] <= (prod_reg[c][0] >>> 2) + (prod_reg[c][1] >>> 2)
                        + (prod_reg[c][2] >>> 2)
                        + $signed({{(POS_PROD_W-ELEM_W-TR_SH){tr_reg[c][ELEM_W-1]}},
                                   tr_reg[c], {TR_SH{1'b0}}});
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            un_reg[c]  <= acc_reg[c][POS_PROD_W-1] ? POS_PROD_W'(-acc_reg[c])
                                                   : POS_PROD_W'(acc_reg[c]);
            neg_reg[c] <= acc_reg[c][POS_PROD_W-1] ^ acc_reg[3][POS_PROD_W-1];
        end
        ud_reg <= acc_reg[3][POS_PROD_W-1] ? POS_PROD_W'(-acc_reg[3]) : POS_PROD_W'(acc_reg[3]);
        wz_reg <= (acc_reg[3] == '0);
    end

    for (genvar k = 1; k <= POS_DIV_STEPS; k++)
    begin : g_div
        logic [POS_PROD_W-1:0] rem_in  [3];
        logic [ELEM_W-1:0]     feed_in [3];
        logic [ELEM_W-1:0]     q_in    [3];
        logic [POS_PROD_W-1:0] ud_in;
        logic [2:0]            ovf_in;
        logic [2:0]            neg_in;
        logic                  wz_in;
        logic [POS_PROD_W:0]   r_w  [3];
        logic [POS_PROD_W+1:0] diff [3];

        if (k == 1)
        begin : g_first
            always_comb
            begin
                for (int c = 0; c < 3; c++)
                begin
                    rem_in[c]  = un_reg[c] >> FRAC_W;
                    feed_in[c] = {un_reg[c][FRAC_W-1:0], {(ELEM_W-FRAC_W){1'b0}}};
                    q_in[c]    = '0;
                    ovf_in[c]  = (un_reg[c] >> FRAC_W) >= ud_reg;
                end
                ud_in  = ud_reg;
                neg_in = neg_reg;
                wz_in  = wz_reg;
            end
        end
        else
        begin : g_next
            always_comb
            begin
                for (int c = 0; c < 3; c++)
                begin
                    rem_in[c]  = drem_reg[k-1][c];
                    feed_in[c] = dfeed_reg[k-1][c];
                    q_in[c]    = dq_reg[k-1][c];
                end
                ovf_in = dovf_reg[k-1];
                ud_in  = dud_reg[k-1];
                neg_in = dneg_reg[k-1];
                wz_in  = dwz_reg[k-1];
            end
        end

        always_comb
        begin
            for (int c = 0; c < 3; c++)
            begin
                r_w[c]  = {rem_in[c], feed_in[c][ELEM_W-1]};
                diff[c] = {1'b0, r_w[c]} - {2'b00, ud_in};
            end
        end

        always_ff @(posedge clk)
        begin
            for (int c = 0; c < 3; c++)
            begin
                drem_reg[k][c]  <= diff[c][POS_PROD_W+1] ? r_w[c][POS_PROD_W-1:0]
                                                         : diff[c][POS_PROD_W-1:0];
                dfeed_reg[k][c] <= feed_in[c] << 1;
                dq_reg[k][c]    <= {q_in[c][ELEM_W-2:0], ~diff[c][POS_PROD_W+1]};
            end
            dud_reg[k]  <= ud_in;
            dovf_reg[k] <= ovf_in;
            dneg_reg[k] <= neg_in;
            dwz_reg[k]  <= wz_in;
        end
    end

    always_comb
    begin
        fin.w_zero_fault = dwz_reg[POS_DIV_STEPS];
        fin.out_x = dwz_reg[POS_DIV_STEPS] ? '0 :
            sat_q(dq_reg[POS_DIV_STEPS][0], dovf_reg[POS_DIV_STEPS][0],
                  dneg_reg[POS_DIV_STEPS][0]);
        fin.out_y = dwz_reg[POS_DIV_STEPS] ? '0 :
            sat_q(dq_reg[POS_DIV_STEPS][1], dovf_reg[POS_DIV_STEPS][1],
                  dneg_reg[POS_DIV_STEPS][1]);
        fin.out_z = dwz_reg[POS_DIV_STEPS] ? '0 :
            sat_q(dq_reg[POS_DIV_STEPS][2], dovf_reg[POS_DIV_STEPS][2],
                  dneg_reg[POS_DIV_STEPS][2]);
    end

    always_ff @(posedge clk)
    begin
        pad_reg[0] <= fin;
        for (int i = 1; i < POS_PAD; i++)
        begin
            pad_reg[i] <= pad_reg[i-1];
        end
    end

    assign res = pad_reg[POS_PAD-1];

endmodule

>>> src/vtn_norm_path.sv
`timescale 1ns / 1ps
// Normal pipeline: 3x3 transform, block normalize, square root and divide to unit length.
// Depends on vtn_pkg; one square root step and one quotient bit per stage.
module vtn_norm_path
(
    input  logic              clk,
    input  vtn_pkg::vtn_in_t  vertex,
    input  vtn_pkg::mat_t     mat,
    output vtn_pkg::nrm_res_t res
);
    import vtn_pkg::*;

    localparam int SIDE_N = NRM_STAGES - 3;

    logic signed [NRM_W-1:0]   n_in [3];
    logic signed [NPROD_W-1:0] prod_reg [3][3];
    logic signed [NV_W-1:0]    nv_reg [3];
    trio_t                     a_reg;
    trio_t                     t4_reg;
    trio_t                     t5_reg;
    trio_t                     t6_reg;
    logic [3:0]                side_reg [SIDE_N];

    logic [NN_W-1:0]  an6 [3];
    logic [SQ_W-1:0]  sq_reg [3];
    logic [NN_W-1:0]  an7_reg [3];
    logic [SUM_W-1:0] sum_reg;
    logic [NN_W-1:0]  an8_reg [3];

    logic [SUM_W-1:0] sv_reg [1:SQRT_STEPS];
    logic [SUM_W-1:0] sr_reg [1:SQRT_STEPS];
    logic [NN_W-1:0]  san_reg [1:SQRT_STEPS][3];

    logic [LEN_W-1:0]         dl_reg    [1:NRM_DIV_STEPS];
    logic [LEN_W-1:0]         drem_reg  [1:NRM_DIV_STEPS][3];
    logic [NRM_DIV_STEPS-1:0] dfeed_reg [1:NRM_DIV_STEPS][3];
    logic [NRM_DIV_STEPS-1:0] dq_reg    [1:NRM_DIV_STEPS][3];

    nrm_res_t res_reg;

    function automatic trio_t norm_step(trio_t v, int unsigned k);
        logic [NA_W-1:0] o;
        trio_t           r;
        o = v[0] | v[1] | v[2];
        r = v;
        if ((o >> (NA_W - k)) == '0)
        begin
            for (int i = 0; i < 3; i++)
            begin
                r[i] = v[i] << k;
            end
        end
        return r;
    endfunction

    assign n_in[0] = vertex.norm_x;
    assign n_in[1] = vertex.norm_y;
    assign n_in[2] = vertex.norm_z;

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                prod_reg[c][r] <= n_in[r] * $signed(mat[r][c]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            nv_reg[c] <= NV_W'(prod_reg[c][0]) + NV_W'(prod_reg[c][1]) + NV_W'(prod_reg[c][2]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            a_reg[c] <= nv_reg[c][NV_W-1] ? NA_W'(-nv_reg[c]) : NA_W'(nv_reg[c]);
        end
        side_reg[0] <= {nv_reg[2][NV_W-1], nv_reg[1][NV_W-1], nv_reg[0][NV_W-1],
                        (nv_reg[0] == '0) && (nv_reg[1] == '0) && (nv_reg[2] == '0)};
        for (int i = 1; i < SIDE_N; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        t4_reg <= norm_step(norm_step(a_reg, 32), 16);
        t5_reg <= norm_step(norm_step(t4_reg, 8), 4);
        t6_reg <= norm_step(norm_step(t5_reg, 2), 1);
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            an6[c] = t6_reg[c][NA_W-1 -: NN_W];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            sq_reg[c]  <= SQ_W'(an6[c]) * SQ_W'(an6[c]);
            an7_reg[c] <= an6[c];
            an8_reg[c] <= an7_reg[c];
        end
        sum_reg <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
    end

    for (genvar k = 1; k <= SQRT_STEPS; k++)
    begin : g_sqrt
        localparam logic [SUM_W-1:0] BIT_K = SUM_W'(1) << (SUM_W - 2 * k);
        logic [SUM_W-1:0] v_in;
        logic [SUM_W-1:0] r_in;
        logic [NN_W-1:0]  an_in [3];
        logic [SUM_W:0]   diff;

        if (k == 1)
        begin : g_first
            always_comb
            begin
                v_in  = sum_reg;
                r_in  = '0;
                an_in = an8_reg;
            end
        end
        else
        begin : g_next
            always_comb
            begin
                v_in  = sv_reg[k-1];
                r_in  = sr_reg[k-1];
                an_in = san_reg[k-1];
            end
        end

        assign diff = {1'b0, v_in} - {1'b0, r_in | BIT_K};

        always_ff @(posedge clk)
        begin
            if (!diff[SUM_W])
            begin
                sv_reg[k] <= diff[SUM_W-1:0];
                sr_reg[k] <= (r_in >> 1) + BIT_K;
            end
            else
            begin
                sv_reg[k] <= v_in;
                sr_reg[k] <= r_in >> 1;
            end
            san_reg[k] <= an_in;
        end
    end

    for (genvar j = 1; j <= NRM_DIV_STEPS; j++)
    begin : g_div
        logic [LEN_W-1:0]         len_in;
        logic [LEN_W-1:0]         rem_in  [3];
        logic [NRM_DIV_STEPS-1:0] feed_in [3];
        logic [NRM_DIV_STEPS-1:0] q_in    [3];
        logic [LEN_W:0]           r_w  [3];
        logic [LEN_W+1:0]         diff [3];

        if (j == 1)
        begin : g_first
            always_comb
            begin
                len_in = sr_reg[SQRT_STEPS][LEN_W-1:0];
                for (int c = 0; c < 3; c++)
                begin
                    rem_in[c]  = LEN_W'(san_reg[SQRT_STEPS][c] >> 1);
                    feed_in[c] = {san_reg[SQRT_STEPS][c][0], {NQ_SH{1'b0}}};
                    q_in[c]    = '0;
                end
            end
        end
        else
        begin : g_next
            always_comb
            begin
                len_in = dl_reg[j-1];
                for (int c = 0; c < 3; c++)
                begin
                    rem_in[c]  = drem_reg[j-1][c];
                    feed_in[c] = dfeed_reg[j-1][c];
                    q_in[c]    = dq_reg[j-1][c];
                end
            end
        end

        always_comb
        begin
            for (int c = 0; c < 3; c++)
            begin
                r_w[c]  = {rem_in[c], feed_in[c][NRM_DIV_STEPS-1]};
                diff[c] = {1'b0, r_w[c]} - {2'b00, len_in};
            end
        end

        always_ff @(posedge clk)
        begin
            for (int c = 0; c < 3; c++)
            begin
                drem_reg[j][c]  <= diff[c][LEN_W+1] ? r_w[c][LEN_W-1:0] : diff[c][LEN_W-1:0];
                dfeed_reg[j][c] <= feed_in[c] << 1;
                dq_reg[j][c]    <= {q_in[c][NRM_DIV_STEPS-2:0], ~diff[c][LEN_W+1]};
            end
            dl_reg[j] <= len_in;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg.normal_zero_fault <= side_reg[SIDE_N-1][0];
        res_reg.out_nx <= side_reg[SIDE_N-1][0] ? '0 : side_reg[SIDE_N-1][1]
            ? -NRM_W'(dq_reg[NRM_DIV_STEPS][0]) : NRM_W'(dq_reg[NRM_DIV_STEPS][0]);
        res_reg.out_ny <= side_reg[SIDE_N-1][0] ? '0 : side_reg[SIDE_N-1][2]
            ? -NRM_W'(dq_reg[NRM_DIV_STEPS][1]) : NRM_W'(dq_reg[NRM_DIV_STEPS][1]);
        res_reg.out_nz <= side_reg[SIDE_N-1][0] ? '0 : side_reg[SIDE_N-1][3]
            ? -NRM_W'(dq_reg[NRM_DIV_STEPS][2]) : NRM_W'(dq_reg[NRM_DIV_STEPS][2]);
    end

    assign res = res_reg;

endmodule

>>> src/vertex_transform_normalize_top.sv
`timescale 1ns / 1ps
// Top level of the vertex transform and normalize block: matrix registers, valid chain.
// Depends on vtn_pkg, vtn_pos_path and vtn_norm_path.
//
// A vertex beat is taken at every rising edge with start high; busy is always low,
// so one vertex can enter on every clock. The position is multiplied by the 4x4
// matrix and divided by w; the normal is multiplied by the upper 3x3 part and
// scaled to unit length. Each vertex gives exactly one result beat, shown on
// result for one cycle with done high.
// Throughput is one vertex per cycle; the latency is set by the normal path,
// whose 32-stage square root and 15-stage divider each resolve one bit per stage.
// The receiver cannot stall, so there is no back pressure anywhere.
// The matrix is written through cfg_we, cfg_index and cfg_wdata, one 64-bit
// register per write; the user must write it only while no vertex is in flight,
// which the block does not enforce. Indices past the last register are ignored.
// Reset loads the identity matrix and empties the pipeline.
module vertex_transform_normalize_top
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  vtn_pkg::vtn_in_t                vertex,
    input  logic                            cfg_we,
    input  logic [vtn_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vtn_pkg::CFG_W-1:0]       cfg_wdata,
    output logic                            done,
    output vtn_pkg::vtn_out_t               result
);
    import vtn_pkg::*;

    logic [CFG_W-1:0]    cfg_reg [NUM_REGS];
    mat_t                mat;
    logic                accept;
    logic [PIPE_LAT:1]   vld_reg;
    logic [PIPE_LAT:1]   last_reg;
    pos_res_t            pos_res;
    nrm_res_t            nrm_res;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                cfg_reg[i] <= REG_RESET[i];
            end
        end
        else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_REGS)))
        begin
            cfg_reg[cfg_index[REG_SEL_W-1:0]] <= cfg_wdata;
        end
    end

    for (genvar r = 0; r < 4; r++)
    begin : g_row
        for (genvar c = 0; c < 4; c++)
        begin : g_col
            assign mat[r][c] = cfg_reg[2 * r + c / 2][ELEM_W * (c % 2) +: ELEM_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[PIPE_LAT-1:1], accept};
    end

    always_ff @(posedge clk)
    begin
        last_reg <= {last_reg[PIPE_LAT-1:1], vertex.last_vertex};
    end

    vtn_pos_path u_pos
    (
        .clk    (clk),
        .vertex (vertex),
        .mat    (mat),
        .res    (pos_res)
    );

    vtn_norm_path u_norm
    (
        .clk    (clk),
        .vertex (vertex),
        .mat    (mat),
        .res    (nrm_res)
    );

    assign done                     = vld_reg[PIPE_LAT];
    assign result.out_x             = pos_res.out_x;
    assign result.out_y             = pos_res.out_y;
    assign result.out_z             = pos_res.out_z;
    assign result.w_zero_fault      = pos_res.w_zero_fault;
    assign result.out_nx            = nrm_res.out_nx;
    assign result.out_ny            = nrm_res.out_ny;
    assign result.out_nz            = nrm_res.out_nz;
    assign result.normal_zero_fault = nrm_res.normal_zero_fault;
    assign result.last_out          = last_reg[PIPE_LAT];

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##PIPE_LAT done)
        else $error("result beat missing after pipeline latency");

    a_wzero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.w_zero_fault) |->
            (result.out_x == '0 && result.out_y == '0 && result.out_z == '0))
        else $error("position not zero on w fault");

    a_nzero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.normal_zero_fault) |->
            (result.out_nx == '0 && result.out_ny == '0 && result.out_nz == '0))
        else $error("normal not zero on normal fault");

    a_unit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.normal_zero_fault) |->
            (result.out_nx <= 16'sd16384 && result.out_nx >= -16'sd16384 &&
             result.out_ny <= 16'sd16384 && result.out_ny >= -16'sd16384 &&
             result.out_nz <= 16'sd16384 && result.out_nz >= -16'sd16384))
        else $error("normal component above unit length");

endmodule
